// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gfe_pkg.sv =====
// shared constants, types and helpers for the forward elimination block
`timescale 1ns / 1ps
`default_nettype none
package gfe_pkg;
  localparam int MaxSize = 8;
  localparam int ValueBits = 32;
  localparam int FracBits = 16;
  localparam int IdxBits = $clog2(MaxSize);
  localparam int CntBits = $clog2(MaxSize + 1);

  typedef logic signed [ValueBits-1:0] val_t;
  typedef val_t [MaxSize-1:0] row_t;

  typedef struct packed {
    logic [IdxBits-1:0] row_index;
    row_t coef;
    val_t rhs;
    logic last_row;
    logic pivot_zero;
  } res_t;

  typedef struct packed {
    row_t coef;
    val_t rhs;
  } in_t;

  // one lane command: multiplier magnitude and sign
  typedef struct packed {
    logic [ValueBits-1:0] m_mag;
    logic m_neg;
  } mul_t;

  localparam logic signed [ValueBits:0] SatHi = (33'sd1 <<< (ValueBits - 1)) - 33'sd1;
  localparam logic signed [ValueBits:0] SatLo = -SatHi - 33'sd1;

  function automatic val_t sat33(input logic signed [ValueBits:0] v);
    val_t r;
    if (v > SatHi) r = SatHi[ValueBits-1:0];
    else if (v < SatLo) r = SatLo[ValueBits-1:0];
    else r = v[ValueBits-1:0];
    return r;
  endfunction

  function automatic logic [ValueBits-1:0] mag(input val_t a);
    logic [ValueBits-1:0] r;
    r = a[ValueBits-1] ? (~a + 1'b1) : a;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/gfe_if.sv =====
// valid/ready channel carrying one beat of payload
`timescale 1ns / 1ps
`default_nettype none
interface gfe_in_if;
  logic valid;
  logic ready;
  gfe_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gfe_out_if;
  logic valid;
  logic ready;
  gfe_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/gfe_div.sv =====
// restoring divider, one quotient bit per cycle, saturating signed Q16.16 quotient
`timescale 1ns / 1ps
`default_nettype none
module gfe_div (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire gfe_pkg::val_t num_i,
  input  wire gfe_pkg::val_t den_i,
  output logic done_o,
  output gfe_pkg::mul_t quo_o
);
  localparam int NumBits = gfe_pkg::ValueBits + gfe_pkg::FracBits;
  localparam int StepBits = $clog2(NumBits + 1);

  logic busy_q, busy_d;
  logic [StepBits-1:0] step_q, step_d;
  logic [NumBits-1:0] num_q, num_d;
  logic [gfe_pkg::ValueBits-1:0] den_q, den_d;
  logic [gfe_pkg::ValueBits:0] rem_q, rem_d;
  logic [NumBits-1:0] quo_q, quo_d;
  logic neg_q, neg_d;
  logic done_q, done_d;
  logic [gfe_pkg::ValueBits:0] trial;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    done_d = 1'b0;
    trial = {rem_q[gfe_pkg::ValueBits-1:0], num_q[NumBits-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d = {gfe_pkg::mag(num_i), {gfe_pkg::FracBits{1'b0}}};
      den_d = gfe_pkg::mag(den_i);
      rem_d = '0;
      quo_d = '0;
      neg_d = num_i[gfe_pkg::ValueBits-1] ^ den_i[gfe_pkg::ValueBits-1];
    end else if (busy_q) begin
      num_d = {num_q[NumBits-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepBits'(NumBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // clamp magnitude: positive max 2^31-1, negative magnitude up to 2^31
  logic big_pos, big_neg;
  assign big_pos = |quo_q[NumBits-1:gfe_pkg::ValueBits-1];
  assign big_neg = (|quo_q[NumBits-1:gfe_pkg::ValueBits])
                 || (quo_q[gfe_pkg::ValueBits-1] && (|quo_q[gfe_pkg::ValueBits-2:0]));
  always_comb begin
    quo_o.m_neg = neg_q;
    if (neg_q) begin
      quo_o.m_mag = big_neg ? {1'b1, {(gfe_pkg::ValueBits-1){1'b0}}}
                            : quo_q[gfe_pkg::ValueBits-1:0];
    end else begin
      quo_o.m_mag = big_pos ? {1'b0, {(gfe_pkg::ValueBits-1){1'b1}}}
                            : quo_q[gfe_pkg::ValueBits-1:0];
    end
  end
  assign done_o = done_q;
endmodule
`default_nettype wire

// ===== hdl/gfe_lane.sv =====
// one column lane: y - m*p with a registered product, saturated
`timescale 1ns / 1ps
`default_nettype none
module gfe_lane (
  input  wire logic clk_i,
  input  wire gfe_pkg::mul_t mul_i,
  input  wire gfe_pkg::val_t piv_i,
  input  wire gfe_pkg::val_t tgt_i,
  output gfe_pkg::val_t res_o
);
  logic [2*gfe_pkg::ValueBits-1:0] prod_q;
  logic neg_q;
  gfe_pkg::val_t tgt_q;
  logic [gfe_pkg::ValueBits:0] p_mag;
  logic signed [gfe_pkg::ValueBits+1:0] diff;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_i.m_mag * gfe_pkg::mag(piv_i);
    neg_q <= mul_i.m_neg ^ piv_i[gfe_pkg::ValueBits-1];
    tgt_q <= tgt_i;
  end

  // any scaled product of 2^32 or more saturates the difference, so clamp it there
  assign p_mag = (|prod_q[2*gfe_pkg::ValueBits-1:gfe_pkg::ValueBits+gfe_pkg::FracBits])
               ? {1'b1, {gfe_pkg::ValueBits{1'b0}}}
               : {1'b0, prod_q[gfe_pkg::FracBits +: gfe_pkg::ValueBits]};
  always_comb begin
    if (neg_q) diff = $signed({{2{tgt_q[gfe_pkg::ValueBits-1]}}, tgt_q}) + $signed({1'b0, p_mag});
    else diff = $signed({{2{tgt_q[gfe_pkg::ValueBits-1]}}, tgt_q}) - $signed({1'b0, p_mag});
    if (diff > $signed({1'b0, gfe_pkg::SatHi})) res_o = gfe_pkg::SatHi[gfe_pkg::ValueBits-1:0];
    else if (diff < $signed({gfe_pkg::SatLo[gfe_pkg::ValueBits], gfe_pkg::SatLo}))
      res_o = gfe_pkg::SatLo[gfe_pkg::ValueBits-1:0];
    else res_o = diff[gfe_pkg::ValueBits-1:0];
  end
endmodule
`default_nettype wire

// ===== hdl/gaussian_forward_elimination.sv =====
// top level: row load, sequencer over pivot/row pairs, column lanes, result emit
// sequence: the last row accepted starts n(n-1)/2 eliminations before the first result,
//   each a divide in StDiv and StWait, then a lane pass through StMul and StWr
//   (StDiv goes straight to StMul when the pivot is zero)
// run order: n load beats, then elimination, then n result beats; rows are taken only in StLoad
// reset: asynchronous active low; size 8, no rows loaded, flag clear, stores undefined
`timescale 1ns / 1ps
`default_nettype none
module gaussian_forward_elimination (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  gfe_in_if.sink in_if,
  gfe_out_if.source out_if
);
  localparam int IB = gfe_pkg::IdxBits;
  localparam int CB = gfe_pkg::CntBits;

  typedef enum logic [5:0] {
    StLoad = 6'b000001, StDiv = 6'b000010, StWait = 6'b000100,
    StMul = 6'b001000, StWr = 6'b010000, StEmit = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] size_q;
  logic [CB-1:0] n;
  logic [CB-1:0] loaded_q, loaded_d;
  logic [IB-1:0] k_q, k_d, i_q, i_d, e_q, e_d;
  logic flag_q, flag_d;
  gfe_pkg::row_t mat_q [gfe_pkg::MaxSize];
  gfe_pkg::val_t rhs_q [gfe_pkg::MaxSize];
  gfe_pkg::mul_t mul_q, mul_d;
  logic div_start, div_done;
  gfe_pkg::mul_t div_quo;
  gfe_pkg::val_t lane_res [gfe_pkg::MaxSize+1];
  gfe_pkg::row_t piv_row, tgt_row;
  logic obuf_v_q;
  gfe_pkg::res_t obuf_q;
  logic out_ok;
  logic [CB-1:0] r_slot;

  always_comb begin
    if (size_q < 4'd2) n = CB'(2);
    else if (size_q > 4'(gfe_pkg::MaxSize)) n = CB'(gfe_pkg::MaxSize);
    else n = size_q[CB-1:0];
  end

  assign piv_row = mat_q[k_q];
  assign tgt_row = mat_q[i_q];
  assign in_if.ready = (state_q == StLoad);
  assign r_slot = (loaded_q >= n) ? '0 : loaded_q;
  assign div_start = (state_q == StDiv) && (piv_row[k_q] != '0);
  assign out_ok = !obuf_v_q || out_if.ready;

  gfe_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(tgt_row[k_q]), .den_i(piv_row[k_q]),
    .done_o(div_done), .quo_o(div_quo)
  );

  for (genvar g = 0; g < gfe_pkg::MaxSize; g++) begin : g_lane
    gfe_lane u_lane (
      .clk_i, .mul_i(mul_q),
      .piv_i(piv_row[g]),
      .tgt_i(tgt_row[g]),
      .res_o(lane_res[g])
    );
  end

  gfe_lane u_rhs_lane (
    .clk_i, .mul_i(mul_q),
    .piv_i(rhs_q[k_q]),
    .tgt_i(rhs_q[i_q]),
    .res_o(lane_res[gfe_pkg::MaxSize])
  );

  always_comb begin
    state_d = state_q;
    loaded_d = loaded_q;
    k_d = k_q;
    i_d = i_q;
    e_d = e_q;
    flag_d = flag_q;
    mul_d = mul_q;
    case (state_q)
      StLoad: begin
        if (in_if.valid) begin
          loaded_d = r_slot + 1'b1;
          if (r_slot + 1'b1 == n) begin
            state_d = StDiv;
            flag_d = 1'b0;
            k_d = '0;
            i_d = IB'(1);
          end
        end
      end
      StDiv: begin
        if (piv_row[k_q] == '0) begin
          flag_d = 1'b1;
          mul_d = '0;
          state_d = StMul;
        end else begin
          state_d = StWait;
        end
      end
      StWait: begin
        if (div_done) begin
          mul_d = div_quo;
          state_d = StMul;
        end
      end
      StMul: state_d = StWr;
      StWr: begin
        if ({1'b0, i_q} + 1'b1 < n) begin
          i_d = i_q + 1'b1;
          state_d = StDiv;
        end else if ({1'b0, k_q} + 2'd2 < n) begin
          k_d = k_q + 1'b1;
          i_d = k_q + 2'd2;
          state_d = StDiv;
        end else begin
          e_d = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_ok) begin
          e_d = e_q + 1'b1;
          if ({1'b0, e_q} + 1'b1 == n) begin
            loaded_d = '0;
            state_d = StLoad;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      size_q <= 4'd8;
      loaded_q <= '0;
      flag_q <= 1'b0;
      k_q <= '0;
      i_q <= '0;
      e_q <= '0;
      obuf_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      loaded_q <= loaded_d;
      flag_q <= flag_d;
      k_q <= k_d;
      i_q <= i_d;
      e_q <= e_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (state_q == StEmit && out_ok) obuf_v_q <= 1'b1;
      else if (out_if.ready) obuf_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    if (state_q == StLoad && in_if.valid) begin
      mat_q[r_slot[IB-1:0]] <= in_if.data.coef;
      rhs_q[r_slot[IB-1:0]] <= in_if.data.rhs;
    end
    // lanes from column k up to n-1; lower columns and those at n or beyond keep their values
    if (state_q == StWr) begin
      for (int j = 0; j < gfe_pkg::MaxSize; j++) begin
        if (j >= k_q && j < n) mat_q[i_q][j] <= lane_res[j];
      end
      rhs_q[i_q] <= lane_res[gfe_pkg::MaxSize];
    end
    if (state_q == StEmit && out_ok) begin
      obuf_q.row_index <= e_q;
      for (int j = 0; j < gfe_pkg::MaxSize; j++) begin
        obuf_q.coef[j] <= (j < n) ? mat_q[e_q][j] : '0;
      end
      obuf_q.rhs <= rhs_q[e_q];
      obuf_q.last_row <= ({1'b0, e_q} + 1'b1 == n);
      obuf_q.pivot_zero <= flag_q;
    end
  end

  assign out_if.valid = obuf_v_q;
  assign out_if.data = obuf_q;
endmodule
`default_nettype wire

// ===== hdl/gfe_checker.sv =====
// port-level checker for the forward elimination block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gfe_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire gfe_pkg::res_t out_data
);
  // while a result is valid, a row may load only if that result is the last row of its run
  `ASSERT_IMPL(a_load_after_run, clk_i, rst_ni, out_valid && in_valid && in_ready, out_data.last_row, "input taken mid result run")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_NEXT(a_row_step, clk_i, rst_ni, out_valid && out_ready && !out_data.last_row, out_valid && out_data.row_index == $past(out_data.row_index) + 3'd1, "result rows out of order")
  `ASSERT_NEXT(a_flag_run, clk_i, rst_ni, out_valid && out_ready && !out_data.last_row, out_data.pivot_zero == $past(out_data.pivot_zero), "flag changed within run")
endmodule

bind gaussian_forward_elimination gfe_checker u_gfe_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire

// ===== bench/tb_gaussian_forward_elimination.sv =====
// testbench for the forward elimination block: row loads, elimination results, size changes
`timescale 1ns / 1ps

class elim_scoreboard;
  bit [3:0] size_reg;
  longint mat[64];
  longint rhs[8];
  int unsigned rows_in;
  gfe_pkg::res_t rows_due[$];
  int unsigned errors;
  int unsigned systems_done;
  int unsigned zero_pivot_systems;

  function new();
    size_reg = 4'd8;
    rows_in = 0;
    errors = 0;
    systems_done = 0;
    zero_pivot_systems = 0;
    foreach (mat[i]) mat[i] = 0;
    foreach (rhs[i]) rhs[i] = 0;
  endfunction

  function int unsigned order();
    if (size_reg < 2) return 2;
    if (size_reg > 8) return 8;
    return size_reg;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint unsigned absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = (absval(a) * absval(b)) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function longint fx_div(longint a, longint d);
    longint unsigned q;
    q = (absval(a) << 16) / absval(d);
    return clamp32(((a < 0) != (d < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function int unsigned pending();
    return rows_due.size();
  endfunction

  // note one accepted row; a completed system queues its triangular rows
  function void note_row(gfe_pkg::in_t d);
    int unsigned n, r;
    longint piv, m;
    bit zp;
    gfe_pkg::res_t res;
    n = order();
    if (rows_in >= n) rows_in = 0;
    r = rows_in;
    for (int j = 0; j < 8; j++) mat[r*8+j] = longint'(d.coef[j]);
    rhs[r] = longint'(d.rhs);
    rows_in = r + 1;
    if (rows_in < n) return;
    zp = 0;
    for (int k = 0; k + 1 < n; k++) begin
      piv = mat[k*8+k];
      for (int i = k + 1; i < n; i++) begin
        if (piv == 0) begin
          m = 0;
          zp = 1;
        end else begin
          m = fx_div(mat[i*8+k], piv);
        end
        rhs[i] = clamp32(rhs[i] - fx_mul(m, rhs[k]));
        for (int j = k; j < n; j++)
          mat[i*8+j] = clamp32(mat[i*8+j] - fx_mul(m, mat[k*8+j]));
      end
    end
    for (int i = 0; i < n; i++) begin
      res.row_index = i[2:0];
      for (int j = 0; j < 8; j++) res.coef[j] = (j < n) ? mat[i*8+j][31:0] : 32'd0;
      res.rhs = rhs[i][31:0];
      res.last_row = (i + 1 == n);
      res.pivot_zero = zp;
      rows_due.push_back(res);
    end
    rows_in = 0;
    systems_done++;
    if (zp) zero_pivot_systems++;
  endfunction

  function void check_row(gfe_pkg::res_t got);
    gfe_pkg::res_t want;
    if (rows_due.size() == 0) begin
      $error("result row %0d with nothing expected", got.row_index);
      errors++;
      return;
    end
    want = rows_due.pop_front();
    if (got.row_index !== want.row_index) begin
      $error("row_index expected %0d actual %0d", want.row_index, got.row_index);
      errors++;
    end
    for (int j = 0; j < 8; j++)
      if (got.coef[j] !== want.coef[j]) begin
        $error("out_%0d expected %h actual %h", j, want.coef[j], got.coef[j]);
        errors++;
      end
    if (got.rhs !== want.rhs) begin
      $error("rhs_out expected %h actual %h", want.rhs, got.rhs);
      errors++;
    end
    if (got.last_row !== want.last_row) begin
      $error("last_row expected %b actual %b", want.last_row, got.last_row);
      errors++;
    end
    if (got.pivot_zero !== want.pivot_zero) begin
      $error("pivot_zero expected %b actual %b", want.pivot_zero, got.pivot_zero);
      errors++;
    end
  endfunction
endclass

module tb_gaussian_forward_elimination;
  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [3:0] cfg_wdata_i;

  gfe_in_if in_bus ();
  gfe_out_if out_bus ();

  gaussian_forward_elimination u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_bus),
    .out_if(out_bus)
  );

  elim_scoreboard sb;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit stall_request;
  int unsigned stall_left;
  int unsigned rows_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("gaussian_forward_elimination verification failed");
    $finish;
  end

  // result side: check accepted beats, drive ready with random gaps and the long hold
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) sb.check_row(out_bus.data);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_request) begin
        stall_request = 0;
        stall_left = 3000;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic gfe_pkg::val_t pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(32'h001fffff)) - 32'sh00100000;
    endcase
  endfunction

  function automatic gfe_pkg::in_t random_row();
    gfe_pkg::in_t d;
    for (int j = 0; j < 8; j++) d.coef[j] = pick_value();
    d.rhs = pick_value();
    return d;
  endfunction

  // valid stays high across back-to-back beats; it drops only for a gap or a stop
  task automatic send_row(gfe_pkg::in_t d);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data <= d;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_row(d);
    rows_sent++;
  endtask

  task automatic stop_rows();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_results();
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_size(bit [3:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.size_reg = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_rows(int unsigned count);
    for (int i = 0; i < count; i++) send_row(random_row());
  endtask

  gfe_pkg::in_t d;
  int unsigned n;

  initial begin
    sb = new();
    tx_idle_pct = 18;
    rx_idle_pct = 18;
    stall_request = 0;
    stall_left = 0;
    rows_sent = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_bus.valid <= 1'b0;
    in_bus.data <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // extremes on a 2x2 system
    set_size(4'd2);
    for (int j = 0; j < 8; j++) d.coef[j] = 32'h7fffffff;
    d.rhs = 32'h80000000;
    send_row(d);
    for (int j = 0; j < 8; j++) d.coef[j] = 32'h80000000;
    d.rhs = 32'h7fffffff;
    send_row(d);
    stop_rows();
    wait_results();

    // zero first pivot
    set_size(4'd3);
    d = random_row();
    d.coef[0] = '0;
    send_row(d);
    send_rows(2);
    stop_rows();
    wait_results();

    // partial load dropped when the size goes below the rows already loaded
    set_size(4'd8);
    send_rows(3);
    stop_rows();
    set_size(4'd2);
    send_rows(2);
    stop_rows();
    wait_results();

    // sizes below two and above eight clamp
    set_size(4'd0);
    send_rows(2);
    stop_rows();
    wait_results();
    set_size(4'd15);
    send_rows(8);
    stop_rows();
    wait_results();

    for (int phase = 0; rows_sent < 170; phase++) begin
      case ($urandom_range(9))
        0: set_size(4'($urandom_range(15)));
        1: set_size(4'd8);
        default: set_size(4'($urandom_range(2, 4)));
      endcase
      n = sb.order();
      tx_idle_pct = (phase >= 6 && phase < 12) ? 0 : 18;
      rx_idle_pct = tx_idle_pct;
      if (phase == 3) begin
        // hold results off while two systems go in, so the input backs up
        stall_request = 1;
        send_rows(2 * n);
      end else if ($urandom_range(7) == 0) begin
        send_rows(n - 1);
      end else begin
        send_rows(n);
      end
      stop_rows();
      wait_results();
    end

    repeat (200) @(posedge clk_i);
    if (sb.pending() > 0) begin
      $error("%0d result rows never arrived", sb.pending());
      sb.errors++;
    end
    $display("covered %0d input rows and %0d eliminated systems, %0d with a zero pivot",
             rows_sent, sb.systems_done, sb.zero_pivot_systems);
    if (sb.errors == 0) begin
      $display("gaussian_forward_elimination verification clean");
    end else begin
      $display("gaussian_forward_elimination verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/gfe_pkg.sv
hdl/gfe_if.sv
hdl/gfe_div.sv
hdl/gfe_lane.sv
hdl/gaussian_forward_elimination.sv
hdl/gfe_checker.sv
bench/tb_gaussian_forward_elimination.sv
